FILE: hw/rtl/fsgs_pkg.sv
`default_nettype none

package fsgs_pkg;

  // Default grid size
  localparam int unsigned GridWidthDef  = 256;
  localparam int unsigned GridHeightDef = 256;

  // Reset value of the direction-choice seed
  localparam logic [15:0] SeedReset = 16'hACE1;

  // Register index of the seed register
  localparam int unsigned RegIdxSeed = 0;

  // Cell type codes
  localparam logic [1:0] CellEmpty = 2'd0;
  localparam logic [1:0] CellSand  = 2'd1;

  // Item kinds
  typedef enum logic [1:0] {
    KindPlace = 2'd0,
    KindStep  = 2'd1,
    KindRead  = 2'd2
  } kind_e;

  // Control from the sequencer to the generation scanner
  typedef struct packed {
    logic start;      // begin a scan pass over the source bank
    logic seed_load;  // load the choice LFSR from the seed register
  } scan_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fsgs_ram.sv
`default_nettype none

module fsgs_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/fsgs_scan.sv
`default_nettype none

module fsgs_scan #(
  parameter int unsigned GridWidth  = fsgs_pkg::GridWidthDef,
  parameter int unsigned GridHeight = fsgs_pkg::GridHeightDef,
  localparam int unsigned CellCount = GridWidth * GridHeight,
  localparam int unsigned AW        = $clog2(CellCount)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fsgs_pkg::scan_ctrl_t ctrl_i,
  input  logic [15:0]          seed_i,
  output logic                 done_o,
  output logic [AW-1:0]        src_raddr_o,
  input  logic [1:0]           src_rdata_i,
  output logic                 dst_we_o,
  output logic [AW-1:0]        dst_waddr_o
);

  localparam int unsigned CW = $clog2(GridWidth + 1);
  localparam int unsigned XW = $clog2(GridWidth);
  localparam int unsigned YW = $clog2(GridHeight);

  // Issue stage: column counter runs one past the grid, rows go bottom to top.
  // Step c reads source column c and settles the cells of column c-1.
  logic          issue_q;
  logic [CW-1:0] c_q;
  logic [YW-1:0] y_q;

  // Settle stage, in the cycle after issue
  logic          p_vld_q;
  logic [CW-1:0] p_c_q;
  logic [YW-1:0] p_y_q;

  // Row below the current one: columns c-2, c-1, c
  logic [1:0]    bl_q, bc_q, br_q;

  logic [15:0]   lfsr_q;
  logic [15:0]   lfsr_d;

  logic [XW-1:0] src_col;
  logic [3:0]    buf_rdata;
  logic [1:0]    left_v, center_v, right_v;
  logic          bottom, left_off, right_off;
  logic          sand, dc, dl, dr, lfsr_step;
  logic [CW-1:0] tx_full;
  logic [YW-1:0] ty;

  // Source read, the right column clamped to the grid on the extra step
  assign src_col     = (c_q == CW'(GridWidth)) ? XW'(GridWidth - 1) : c_q[XW-1:0];
  assign src_raddr_o = AW'(y_q) * AW'(GridWidth) + AW'(src_col);

  // Column buffer: [1:0] column c-2, [3:2] column c-1, one entry per row
  fsgs_ram #(
    .Width (4),
    .Depth (GridHeight)
  ) u_colbuf (
    .clk_i   (clk_i),
    .we_i    (p_vld_q),
    .waddr_i (p_y_q),
    .wdata_i ({src_rdata_i, buf_rdata[3:2]}),
    .raddr_i (y_q),
    .rdata_o (buf_rdata)
  );

  assign left_v   = buf_rdata[1:0];
  assign center_v = buf_rdata[3:2];
  assign right_v  = src_rdata_i;

  // Neighbor tests, off grid counts as blocked
  assign bottom    = (p_y_q == YW'(GridHeight - 1));
  assign left_off  = (p_c_q == CW'(1));
  assign right_off = (p_c_q == CW'(GridWidth));
  assign sand      = p_vld_q && (p_c_q != '0) && (center_v == fsgs_pkg::CellSand);
  assign dc        = !bottom && (bc_q == fsgs_pkg::CellEmpty);
  assign dl        = !bottom && !left_off && (bl_q == fsgs_pkg::CellEmpty);
  assign dr        = !bottom && !right_off && (br_q == fsgs_pkg::CellEmpty);
  assign lfsr_step = sand && !dc && dl && dr;

  // Shift right, feedback from taps 0, 2, 3, 5; new bit 0 is old bit 1
  assign lfsr_d = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};

  // Landing place of the grain
  always_comb begin
    tx_full = p_c_q - CW'(1);
    ty      = p_y_q + YW'(1);
    if (dc) begin
      tx_full = p_c_q - CW'(1);
    end else if (dl && (!dr || lfsr_q[1])) begin
      tx_full = p_c_q - CW'(2);
    end else if (dr) begin
      tx_full = p_c_q;
    end else begin
      ty = p_y_q;
    end
  end

  assign dst_we_o    = sand;
  assign dst_waddr_o = AW'(ty) * AW'(GridWidth) + AW'(tx_full[XW-1:0]);
  assign done_o      = p_vld_q && (p_c_q == CW'(GridWidth)) && (p_y_q == '0);

  // Scan counters and LFSR
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
      c_q     <= '0;
      y_q     <= '0;
      p_vld_q <= 1'b0;
      p_c_q   <= '0;
      p_y_q   <= '0;
      lfsr_q  <= fsgs_pkg::SeedReset;
    end else begin
      if (ctrl_i.start) begin
        issue_q <= 1'b1;
        c_q     <= '0;
        y_q     <= YW'(GridHeight - 1);
      end else if (issue_q) begin
        if (y_q == '0) begin
          y_q <= YW'(GridHeight - 1);
          if (c_q == CW'(GridWidth)) begin
            issue_q <= 1'b0;
          end else begin
            c_q <= c_q + CW'(1);
          end
        end else begin
          y_q <= y_q - YW'(1);
        end
      end
      p_vld_q <= issue_q;
      p_c_q   <= c_q;
      p_y_q   <= y_q;
      if (ctrl_i.seed_load) begin
        lfsr_q <= seed_i;
      end else if (lfsr_step) begin
        lfsr_q <= lfsr_d;
      end
    end
  end

  // Below-row window follows the settle stage
  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      bl_q <= left_v;
      bc_q <= center_v;
      br_q <= right_v;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/falling_sand_grid_step_core.sv
// Place: the cell is written as the beat is taken; read: one grid memory read before the result.
// Generation: one pass that clears the destination bank, then one cell per cycle
// through the source bank. One item at a time; the next beat is taken once the
// result sits in the output register.
// Reset: the seed register and the LFSR load 44257, then a pass over the grid clears it
// while s_axis_tready stays low; APB writes are taken throughout.
`default_nettype none

module falling_sand_grid_step_core #(
  parameter int unsigned GridWidth  = fsgs_pkg::GridWidthDef,
  parameter int unsigned GridHeight = fsgs_pkg::GridHeightDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // col[7:0], row[15:8], cell_value[17:16], zero pad
  input  logic [1:0]  s_axis_tuser,   // kind[1:0]
  // result beats
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_value[1:0], zero pad
  output logic [1:0]  m_axis_tuser,   // done_kind[1:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CellCount = GridWidth * GridHeight;
  localparam int unsigned AW        = $clog2(CellCount);

  typedef enum logic [2:0] {
    StInit,
    StIdle,
    StRead,
    StClear,
    StScan,
    StResp
  } state_e;

  state_e        state_q;
  logic          cur_q;
  logic [AW-1:0] clr_cnt_q;
  logic          clr_last;
  logic [15:0]   seed_q;
  logic          on_grid_q;
  logic [1:0]    res_kind_q;
  logic [1:0]    res_val_q;
  logic          m_valid_q;
  logic [1:0]    m_kind_q;
  logic [1:0]    m_val_q;

  logic          in_acc;
  logic [1:0]    in_kind;
  logic [7:0]    in_col, in_row;
  logic [1:0]    in_val;
  logic          on_grid;
  logic [AW-1:0] item_addr;

  logic          reg_idx;
  logic          cfg_we;

  fsgs_pkg::scan_ctrl_t scan_ctrl;
  logic          scan_done;
  logic [AW-1:0] scan_raddr;
  logic          scan_we;
  logic [AW-1:0] scan_waddr;

  logic          cur_we, dst_we;
  logic [AW-1:0] cur_waddr, dst_waddr, src_raddr;
  logic [1:0]    cur_wdata, dst_wdata;
  logic [1:0]    bank_rdata [2];
  logic [1:0]    src_rdata;

  // Input beat fields
  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_kind       = s_axis_tuser[1:0];
  assign in_col        = s_axis_tdata[7:0];
  assign in_row        = s_axis_tdata[15:8];
  assign in_val        = s_axis_tdata[17:16];
  assign on_grid       = (32'(in_col) < GridWidth) && (32'(in_row) < GridHeight);
  assign item_addr     = AW'(in_row) * AW'(GridWidth) + AW'(in_col);

  // APB register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == 1'(fsgs_pkg::RegIdxSeed));
  assign prdata  = (reg_idx == 1'(fsgs_pkg::RegIdxSeed)) ? {16'h0000, seed_q} : 32'h0;

  assign clr_last = (clr_cnt_q == AW'(CellCount - 1));

  // Scanner control
  assign scan_ctrl.start     = (state_q == StClear) && clr_last;
  assign scan_ctrl.seed_load = cfg_we;

  fsgs_scan #(
    .GridWidth  (GridWidth),
    .GridHeight (GridHeight)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (scan_ctrl),
    .seed_i      (pwdata[15:0]),
    .done_o      (scan_done),
    .src_raddr_o (scan_raddr),
    .src_rdata_i (src_rdata),
    .dst_we_o    (scan_we),
    .dst_waddr_o (scan_waddr)
  );

  // Current bank: reset clearing pass or place; other bank: clear pass or grains
  always_comb begin
    cur_we    = 1'b0;
    cur_waddr = item_addr;
    cur_wdata = in_val;
    if (state_q == StInit) begin
      cur_we    = 1'b1;
      cur_waddr = clr_cnt_q;
      cur_wdata = fsgs_pkg::CellEmpty;
    end else if (in_acc && (in_kind == fsgs_pkg::KindPlace) && on_grid) begin
      cur_we = 1'b1;
    end
  end

  assign dst_we    = (state_q == StClear) || scan_we;
  assign dst_waddr = (state_q == StClear) ? clr_cnt_q : scan_waddr;
  assign dst_wdata = (state_q == StClear) ? fsgs_pkg::CellEmpty : fsgs_pkg::CellSand;
  assign src_raddr = (state_q == StScan) ? scan_raddr : item_addr;

  // Two grid banks, swapped after each generation
  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic sel;
    assign sel = (cur_q == 1'(b));
    fsgs_ram #(
      .Width (2),
      .Depth (CellCount)
    ) u_grid (
      .clk_i   (clk_i),
      .we_i    (sel ? cur_we : dst_we),
      .waddr_i (sel ? cur_waddr : dst_waddr),
      .wdata_i (sel ? cur_wdata : dst_wdata),
      .raddr_i (src_raddr),
      .rdata_o (bank_rdata[b])
    );
  end

  assign src_rdata = bank_rdata[cur_q];

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StInit;
      cur_q      <= 1'b0;
      clr_cnt_q  <= '0;
      seed_q     <= fsgs_pkg::SeedReset;
      on_grid_q  <= 1'b0;
      res_kind_q <= '0;
      res_val_q  <= '0;
      m_valid_q  <= 1'b0;
      m_kind_q   <= '0;
      m_val_q    <= '0;
    end else begin
      if (cfg_we) begin
        seed_q <= pwdata[15:0];
      end
      // StResp reloads the output register itself
      if (m_valid_q && m_axis_tready && (state_q != StResp)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        StInit: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_last) begin
            clr_cnt_q <= '0;
            state_q   <= StIdle;
          end
        end
        StIdle: begin
          if (in_acc) begin
            res_kind_q <= in_kind;
            res_val_q  <= fsgs_pkg::CellEmpty;
            on_grid_q  <= on_grid;
            case (in_kind)
              fsgs_pkg::KindStep: state_q <= StClear;
              fsgs_pkg::KindRead: state_q <= StRead;
              default:            state_q <= StResp;
            endcase
          end
        end
        StRead: begin
          res_val_q <= on_grid_q ? src_rdata : fsgs_pkg::CellEmpty;
          state_q   <= StResp;
        end
        StClear: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_last) begin
            clr_cnt_q <= '0;
            state_q   <= StScan;
          end
        end
        StScan: begin
          if (scan_done) begin
            cur_q   <= ~cur_q;
            state_q <= StResp;
          end
        end
        StResp: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_kind_q  <= res_kind_q;
            m_val_q   <= res_val_q;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_kind_q;
  assign m_axis_tdata  = {6'b000000, m_val_q};

endmodule

`default_nettype wire

FILE: hw/rtl/fsgs_checker.sv
`default_nettype none

module fsgs_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       pready
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // Only reads carry a cell value
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != fsgs_pkg::KindRead) |-> m_axis_tdata == 8'h00)
    else $error("nonzero value on a non-read result");

  // One item in flight: no beat taken right after another
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // Grid clearing pass follows reset
  a_reset_clear: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input ready before the grid is cleared");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind falling_sand_grid_step_core fsgs_checker u_checker (.*);

`default_nettype wire
